// ----- sv/mau_pkg.sv -----
package mau_pkg;

	localparam int DEF_WIDTH = 63;

	typedef enum logic [1:0] {
		MODE_ADD = 2'd0,
		MODE_SUB = 2'd1,
		MODE_MUL = 2'd2,
		MODE_DIV = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RED_A,
		S_FIN_A,
		S_RED_B,
		S_FIN_B,
		S_ADDSUB,
		S_MUL_AB,
		S_MUL,
		S_MUL_FIN,
		S_E_CHECK,
		S_E_DIV,
		S_E_MULQ,
		S_E_UPD,
		S_NOINV,
		S_EMIT
	} state_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_DSTEP,
		OP_DFIN_A,
		OP_DFIN_B,
		OP_ADDSUB,
		OP_MINIT_AB,
		OP_MINIT_QT,
		OP_MINIT_AI,
		OP_MSTEP,
		OP_MFIN,
		OP_DINIT_E,
		OP_EUPD,
		OP_NOINV,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  r1_zero;
		logic  r0_one;
	} status_t;

endpackage

// ----- sv/mau_if.sv -----
interface mau_in_if import mau_pkg::*; #(parameter int W = DEF_WIDTH);
	logic         valid;
	logic         ready;
	logic [1:0]   mode;
	logic [W-1:0] operand_a;
	logic [W-1:0] operand_b;
	modport source (output valid, mode, operand_a, operand_b, input ready);
	modport sink (input valid, mode, operand_a, operand_b, output ready);
endinterface

interface mau_out_if import mau_pkg::*; #(parameter int W = DEF_WIDTH);
	logic         valid;
	logic         ready;
	logic [W-1:0] value;
	logic         no_inverse;
	modport source (output valid, value, no_inverse, input ready);
	modport sink (input valid, value, no_inverse, output ready);
endinterface

interface mau_cfg_if import mau_pkg::*; #(parameter int W = DEF_WIDTH);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ----- sv/mau_dp.sv -----
module mau_dp import mau_pkg::*; #(
	parameter int W = DEF_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  cmd_t         cmd,
	output status_t      status,
	input  logic         cfg_we,
	input  logic [W-1:0] cfg_data,
	input  logic [1:0]   in_mode,
	input  logic [W-1:0] in_a,
	input  logic [W-1:0] in_b,
	output logic [W-1:0] out_value,
	output logic         out_flag
);

	logic [W-1:0] modulus_q, m_q, b_q;
	mode_t        mode_q;
	logic [W-1:0] num_q, rem_q, den_q;
	logic [W-1:0] ra_q, rb_q;
	logic [W-1:0] acc_q, mx_q, my_q;
	logic [W-1:0] r0_q, r1_q, t0_q, t1_q;
	logic [W-1:0] res_q, out_value_q;
	logic         res_flag_q, out_flag_q;

	function automatic logic [W-1:0] madd(input logic [W-1:0] x, y, m);
		logic [W:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, m})
			s = s - {1'b0, m};
		return s[W-1:0];
	endfunction

	function automatic logic [W-1:0] msub(input logic [W-1:0] x, y, m);
		return (x >= y) ? x - y : x + (m - y);
	endfunction

	logic [W-1:0] m_eff;
	logic [W:0]   div_t, div_sub;
	logic         div_ge;
	logic [W-1:0] dbl, addv, q_mod, t1_init;

	assign m_eff   = (modulus_q == '0) ? W'(1) : modulus_q;
	assign div_t   = {rem_q, num_q[W-1]};
	assign div_sub = div_t - {1'b0, den_q};
	assign div_ge  = div_t >= {1'b0, den_q};
	assign dbl     = madd(acc_q, acc_q, m_q);
	assign addv    = madd(dbl, mx_q, m_q);
	// quotient never exceeds the modulus, so one compare reduces it
	assign q_mod   = (num_q == m_q) ? '0 : num_q;
	assign t1_init = {{(W-1){1'b0}}, m_q != W'(1)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= W'(1);
		end else if (cfg_we) begin
			modulus_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_NOP: begin
			end
			OP_LOAD: begin
				mode_q <= mode_t'(in_mode);
				b_q    <= in_b;
				m_q    <= m_eff;
				den_q  <= m_eff;
				num_q  <= in_a;
				rem_q  <= '0;
			end
			OP_DSTEP: begin
				rem_q <= div_ge ? div_sub[W-1:0] : div_t[W-1:0];
				num_q <= {num_q[W-2:0], div_ge};
			end
			OP_DFIN_A: begin
				ra_q  <= rem_q;
				num_q <= b_q;
				den_q <= m_q;
				rem_q <= '0;
			end
			OP_DFIN_B: begin
				rb_q <= rem_q;
				r0_q <= m_q;
				r1_q <= rem_q;
				t0_q <= '0;
				t1_q <= t1_init;
			end
			OP_ADDSUB: begin
				res_q      <= (mode_q == MODE_ADD) ? madd(ra_q, rb_q, m_q)
				                                   : msub(ra_q, rb_q, m_q);
				res_flag_q <= 1'b0;
			end
			OP_MINIT_AB: begin
				mx_q  <= ra_q;
				my_q  <= rb_q;
				acc_q <= '0;
			end
			OP_MINIT_QT: begin
				mx_q  <= t1_q;
				my_q  <= q_mod;
				acc_q <= '0;
			end
			OP_MINIT_AI: begin
				mx_q  <= ra_q;
				my_q  <= t0_q;
				acc_q <= '0;
			end
			OP_MSTEP: begin
				acc_q <= my_q[W-1] ? addv : dbl;
				my_q  <= {my_q[W-2:0], 1'b0};
			end
			OP_MFIN: begin
				res_q      <= acc_q;
				res_flag_q <= 1'b0;
			end
			OP_DINIT_E: begin
				num_q <= r0_q;
				den_q <= r1_q;
				rem_q <= '0;
			end
			OP_EUPD: begin
				r0_q <= r1_q;
				r1_q <= rem_q;
				t0_q <= t1_q;
				t1_q <= msub(t0_q, acc_q, m_q);
			end
			OP_NOINV: begin
				res_q      <= '0;
				res_flag_q <= 1'b1;
			end
			OP_EMIT: begin
				out_value_q <= res_q;
				out_flag_q  <= res_flag_q;
			end
			default: begin
			end
		endcase
	end

	assign status.mode    = mode_q;
	assign status.r1_zero = (r1_q == '0);
	assign status.r0_one  = (r0_q == W'(1));
	assign out_value      = out_value_q;
	assign out_flag       = out_flag_q;

endmodule

// ----- sv/mau_ctrl.sv -----
module mau_ctrl import mau_pkg::*; #(
	parameter int W = DEF_WIDTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t status,
	output cmd_t    cmd
);

	localparam int CW = $clog2(W);

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic          euclid_q, out_valid_q;
	logic          last, slot_free;

	assign last      = (cnt_q == CW'(W - 1));
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:    if (in_valid) state_d = S_RED_A;
			S_RED_A:   if (last) state_d = S_FIN_A;
			S_FIN_A:   state_d = S_RED_B;
			S_RED_B:   if (last) state_d = S_FIN_B;
			S_FIN_B: begin
				unique case (status.mode)
					MODE_ADD, MODE_SUB: state_d = S_ADDSUB;
					MODE_MUL:           state_d = S_MUL_AB;
					MODE_DIV:           state_d = S_E_CHECK;
					default:            state_d = S_E_CHECK;
				endcase
			end
			S_ADDSUB:  state_d = S_EMIT;
			S_MUL_AB:  state_d = S_MUL;
			S_MUL:     if (last) state_d = euclid_q ? S_E_UPD : S_MUL_FIN;
			S_MUL_FIN: state_d = S_EMIT;
			S_E_CHECK: begin
				priority if (!status.r1_zero) state_d = S_E_DIV;
				else if (status.r0_one)       state_d = S_MUL_AB;
				else                          state_d = S_NOINV;
			end
			S_E_DIV:   if (last) state_d = S_E_MULQ;
			S_E_MULQ:  state_d = S_MUL;
			S_E_UPD:   state_d = S_E_CHECK;
			S_NOINV:   state_d = S_EMIT;
			S_EMIT:    if (slot_free) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op = OP_NOP;
		unique case (state_q)
			S_IDLE:    if (in_valid) cmd.op = OP_LOAD;
			S_RED_A, S_RED_B, S_E_DIV: cmd.op = OP_DSTEP;
			S_FIN_A:   cmd.op = OP_DFIN_A;
			S_FIN_B:   cmd.op = OP_DFIN_B;
			S_ADDSUB:  cmd.op = OP_ADDSUB;
			S_MUL_AB:  cmd.op = (status.mode == MODE_DIV) ? OP_MINIT_AI : OP_MINIT_AB;
			S_MUL:     cmd.op = OP_MSTEP;
			S_MUL_FIN: cmd.op = OP_MFIN;
			S_E_CHECK: if (!status.r1_zero) cmd.op = OP_DINIT_E;
			S_E_MULQ:  cmd.op = OP_MINIT_QT;
			S_E_UPD:   cmd.op = OP_EUPD;
			S_NOINV:   cmd.op = OP_NOINV;
			S_EMIT:    if (slot_free) cmd.op = OP_EMIT;
			default:   cmd.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			euclid_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q)
				cnt_q <= '0;
			else if (state_q == S_RED_A || state_q == S_RED_B ||
			         state_q == S_E_DIV || state_q == S_MUL)
				cnt_q <= cnt_q + CW'(1);
			if (state_q == S_E_MULQ)
				euclid_q <= 1'b1;
			else if (state_q == S_MUL_AB)
				euclid_q <= 1'b0;
			if (state_q == S_EMIT && slot_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == S_RED_A)
		else $error("accepted transaction did not start reduction");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_EMIT) |-> (!out_valid_q || out_ready))
		else $error("result overwritten before it was taken");
	a_cnt_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL && $past(state_q) != S_MUL) |-> cnt_q == '0)
		else $error("bit counter not cleared on multiply entry");
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_EMIT) |=> out_valid_q)
		else $error("emitted result not flagged valid");

endmodule

// ----- sv/modular_arithmetic_unit.sv -----
// modular arithmetic unit: add, subtract, multiply or divide under a configured modulus
// channels
//   cfg      : write channel for the modulus, always ready; write only while idle
//   operands : mode, operand_a, operand_b; ready only while no transaction is in work
//   result   : value and no_inverse, held in an output register until taken
// both operands are first reduced by a bit-serial restoring divider
// then add and subtract apply a modular add or subtract, multiply runs shift-add (one bit
// a cycle)
// divide runs extended euclid: each round is one serial division plus one serial
// modular multiply, and rounds are bounded by the bit length of the modulus times
// about 1.44; then one more multiply by the inverse
// throughput: one transaction at a time, the next is taken once the result is
// written to the output register; a stalled receiver only holds the block in its
// emit state, the previous result stays put until ready
// reset: modulus back to 1, no result pending, controller idle
module modular_arithmetic_unit import mau_pkg::*; #(
	parameter int WIDTH = DEF_WIDTH
) (
	input logic      clk,
	input logic      arst_n,
	mau_cfg_if.sink  cfg,
	mau_in_if.sink   operands,
	mau_out_if.source result
);

	cmd_t    cmd;
	status_t status;

	// modulus register is always writable
	assign cfg.ready = 1'b1;

	// sequencer: reductions, euclid rounds and multiply iterations
	mau_ctrl #(.W(WIDTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (operands.valid),
		.in_ready  (operands.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath: serial divider, serial modular multiplier, euclid registers
	mau_dp #(.W(WIDTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg.valid),
		.cfg_data  (cfg.data),
		.in_mode   (operands.mode),
		.in_a      (operands.operand_a),
		.in_b      (operands.operand_b),
		.out_value (result.value),
		.out_flag  (result.no_inverse)
	);

endmodule

// ----- sim/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import mau_pkg::*;

	localparam int W = DEF_WIDTH;
	localparam logic [W-1:0] VMAX = {W{1'b1}};
	// longest wait with nothing moving: a 63-bit divide plus the long receiver hold-off
	localparam int STALL_LIMIT = 200000;
	localparam int LONG_HOLD = 2000;

	typedef logic [W-1:0] word_t;

	// one expected result
	typedef struct {
		word_t value;
		logic  no_inv;
	} result_t;

	// one row of the directed table; known = 1 means the expected result is typed in
	typedef struct {
		word_t modulus;
		mode_t mode;
		word_t a;
		word_t b;
		bit    known;
		word_t value;
		logic  no_inv;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mau_cfg_if #(W) cfg_bus ();
	mau_in_if  #(W) opnd_bus ();
	mau_out_if #(W) res_bus ();

	modular_arithmetic_unit #(.WIDTH(W)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_bus),
		.operands (opnd_bus),
		.result   (res_bus)
	);

	// 12 ns period
	always #6 clk = ~clk;

	result_t pending_q[$];   // results still owed by the block, oldest first
	word_t   modulus_shadow; // modulus as the block holds it
	int      errors = 0;
	int      n_in = 0;
	int      n_out = 0;
	int      n_div_noinv = 0;
	int      idle_cycles = 0;
	bit      long_hold_done = 0;

	// ---------------------------------------------------------------
	// arithmetic in wide integers, independent of the serial datapath
	// ---------------------------------------------------------------
	function automatic word_t mod_mul(word_t x, word_t y, word_t m);
		logic [2*W-1:0] p;
		p = {{W{1'b0}}, x} * {{W{1'b0}}, y};
		return W'(p % {{W{1'b0}}, m});
	endfunction

	function automatic word_t mod_sub(word_t x, word_t y, word_t m);
		return (x >= y) ? x - y : x + (m - y);
	endfunction

	// expected result of one operand transaction under modulus mod_reg
	function automatic result_t predict_result(mode_t mode, word_t a_in, word_t b_in,
			word_t mod_reg);
		result_t r;
		word_t m, a, b, r0, r1, r2, t0, t1, t2, q;
		logic [W:0] s;
		m = (mod_reg == '0) ? word_t'(1) : mod_reg; // zero modulus counts as one
		a = a_in % m;
		b = b_in % m;
		r.value = '0;
		r.no_inv = 1'b0;
		case (mode)
			MODE_ADD: begin
				s = {1'b0, a} + {1'b0, b};
				r.value = (s >= {1'b0, m}) ? W'(s - {1'b0, m}) : W'(s);
			end
			MODE_SUB: r.value = mod_sub(a, b, m);
			MODE_MUL: r.value = mod_mul(a, b, m);
			default: begin
				// extended euclid, coefficient of b kept reduced
				r0 = m;
				r1 = b;
				t0 = '0;
				t1 = word_t'(1) % m;
				while (r1 != '0) begin
					q = r0 / r1;
					r2 = r0 - q * r1;
					t2 = mod_sub(t0, mod_mul(q % m, t1, m), m);
					r0 = r1;
					r1 = r2;
					t0 = t1;
					t1 = t2;
				end
				if (r0 == word_t'(1)) begin
					r.value = mod_mul(a, t0, m);
				end else begin
					r.no_inv = 1'b1;
				end
			end
		endcase
		return r;
	endfunction

	// ---------------------------------------------------------------
	// reporting and watchdog
	// ---------------------------------------------------------------
	task automatic report_mismatch(string what);
		errors++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	// counts cycles in which no transaction moves on any channel
	always @(posedge clk) begin
		if ((opnd_bus.valid && opnd_bus.ready) || (res_bus.valid && res_bus.ready) ||
				(cfg_bus.valid && cfg_bus.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// result side: random stalls, one long hold-off, in-order compare
	// ---------------------------------------------------------------
	initial begin
		int stall;
		result_t got, want;
		res_bus.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, 9);
			// every third item or so the receiver takes results back to back
			if ($urandom_range(0, 2) == 0) stall = 0;
			if (!long_hold_done && n_in >= 300) begin
				// long hold-off while the sender keeps offering, block backs up
				stall = LONG_HOLD;
				long_hold_done = 1;
			end
			if (stall > 0) begin
				res_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_bus.ready <= 1'b1;
			do @(posedge clk); while (!res_bus.valid);
			got.value = res_bus.value;
			got.no_inv = res_bus.no_inverse;
			n_out++;
			if (pending_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result value=%0d no_inverse=%0b",
					got.value, got.no_inv));
			end else begin
				want = pending_q.pop_front();
				if (got.value !== want.value)
					report_mismatch($sformatf("value %0d, expected %0d (result %0d)",
						got.value, want.value, n_out));
				if (got.no_inv !== want.no_inv)
					report_mismatch($sformatf("no_inverse %0b, expected %0b (result %0d)",
						got.no_inv, want.no_inv, n_out));
			end
		end
	end

	// ---------------------------------------------------------------
	// operand side
	// ---------------------------------------------------------------
	// offers one transaction after a random gap; valid stays high across a zero gap
	task automatic send_operands(mode_t mode, word_t a, word_t b, bit known,
			result_t typed);
		int gap;
		result_t want;
		gap = $urandom_range(0, 9);
		if ($urandom_range(0, 2) == 0) gap = 0;
		if (gap > 0) begin
			opnd_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		opnd_bus.valid <= 1'b1;
		opnd_bus.mode <= mode;
		opnd_bus.operand_a <= a;
		opnd_bus.operand_b <= b;
		do @(posedge clk); while (!opnd_bus.ready);
		want = known ? typed : predict_result(mode, a, b, modulus_shadow);
		if (want.no_inv) n_div_noinv++;
		pending_q.push_back(want);
		n_in++;
	endtask

	// lets the block drain completely, then waits out its tail
	task automatic drain_block();
		opnd_bus.valid <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// modulus write, only ever called with the block idle
	task automatic write_modulus(word_t m);
		drain_block();
		cfg_bus.valid <= 1'b1;
		cfg_bus.data <= m;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		modulus_shadow = m;
	endtask

	// operand generator mixing full-width noise with values around the modulus
	function automatic word_t pick_operand(word_t m);
		word_t v;
		case ($urandom_range(0, 6))
			0: v = '0;
			1: v = VMAX;
			2: v = word_t'($urandom_range(0, 20));
			3: v = (m > 20) ? m - word_t'($urandom_range(1, 20)) : word_t'($urandom_range(0, 20));
			4: v = m + word_t'($urandom_range(0, 3));
			default: v = word_t'({$urandom, $urandom});
		endcase
		return v;
	endfunction

	// directed rows: reset modulus, zero modulus, small prime, composite, largest
	row_t rows[] = '{
		'{word_t'(1),  MODE_ADD, VMAX, VMAX, 1, '0, 1'b0},
		'{word_t'(1),  MODE_MUL, VMAX, VMAX, 1, '0, 1'b0},
		'{word_t'(1),  MODE_DIV, word_t'(5), '0, 1, '0, 1'b0},
		'{'0,          MODE_SUB, word_t'(3), word_t'(9), 1, '0, 1'b0},
		'{'0,          MODE_DIV, word_t'(1), word_t'(1), 1, '0, 1'b0},
		'{word_t'(13), MODE_ADD, word_t'(12), word_t'(1), 1, '0, 1'b0},
		'{word_t'(13), MODE_SUB, '0, word_t'(1), 1, word_t'(12), 1'b0},
		'{word_t'(13), MODE_MUL, word_t'(12), word_t'(12), 1, word_t'(1), 1'b0},
		'{word_t'(13), MODE_DIV, word_t'(5), '0, 1, '0, 1'b1},
		'{word_t'(13), MODE_DIV, word_t'(5), word_t'(26), 1, '0, 1'b1},
		'{word_t'(13), MODE_DIV, word_t'(7), word_t'(1), 1, word_t'(7), 1'b0},
		'{word_t'(13), MODE_DIV, VMAX, VMAX, 0, '0, 1'b0},
		'{word_t'(12), MODE_DIV, word_t'(1), word_t'(4), 1, '0, 1'b1},
		'{word_t'(12), MODE_DIV, word_t'(1), word_t'(5), 1, word_t'(5), 1'b0},
		'{word_t'(12), MODE_MUL, word_t'(11), word_t'(11), 1, word_t'(1), 1'b0},
		'{VMAX,        MODE_ADD, VMAX, VMAX, 1, '0, 1'b0},
		'{VMAX,        MODE_SUB, '0, word_t'(1), 1, VMAX - 1, 1'b0},
		'{VMAX,        MODE_DIV, word_t'(3), VMAX, 1, '0, 1'b0 | 1'b1},
		'{VMAX,        MODE_MUL, VMAX - 1, VMAX - 1, 0, '0, 1'b0},
		'{VMAX,        MODE_DIV, VMAX - 1, word_t'(2), 0, '0, 1'b0},
		'{VMAX,        MODE_DIV, word_t'({$urandom, $urandom}),
			word_t'({$urandom, $urandom}), 0, '0, 1'b0}
	};

	// random phases: mostly small moduli, a couple of full-width ones with few items
	word_t phase_mod[] = '{word_t'(2), word_t'(3), word_t'(7), word_t'(97), word_t'(128),
		word_t'(255), word_t'(256), word_t'(1), '0, word_t'(65521), word_t'(1000),
		VMAX, {1'b1, 30'($urandom), 32'($urandom)}, word_t'($urandom_range(2, 4000))};
	int phase_len[] = '{100, 100, 100, 110, 100, 110, 100, 40, 40, 90, 110, 25, 25, 110};

	initial begin
		result_t typed;
		word_t m, a, b;
		mode_t mode;
		cfg_bus.valid <= 1'b0;
		cfg_bus.data <= '0;
		opnd_bus.valid <= 1'b0;
		opnd_bus.mode <= MODE_ADD;
		opnd_bus.operand_a <= '0;
		opnd_bus.operand_b <= '0;
		modulus_shadow = word_t'(1); // modulus after reset
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, modulus rewritten only where the row asks for another one
		foreach (rows[i]) begin
			if (rows[i].modulus != modulus_shadow) write_modulus(rows[i].modulus);
			typed.value = rows[i].value;
			typed.no_inv = rows[i].no_inv;
			send_operands(rows[i].mode, rows[i].a, rows[i].b, rows[i].known, typed);
		end

		// random phases
		foreach (phase_mod[p]) begin
			write_modulus(phase_mod[p]);
			m = (phase_mod[p] == '0) ? word_t'(1) : phase_mod[p];
			for (int k = 0; k < phase_len[p]; k++) begin
				mode = mode_t'($urandom_range(0, 3));
				a = pick_operand(m);
				b = pick_operand(m);
				// divisors sharing a factor with the modulus, to reach the no-inverse path
				if (mode == MODE_DIV && $urandom_range(0, 3) == 0)
					b = (m % 2 == 0) ? word_t'(2 * $urandom_range(0, 50)) : m * word_t'(
						$urandom_range(0, 1));
				send_operands(mode, a, b, 0, typed);
			end
		end

		drain_block();
		$display("covered %0d operand transactions and %0d results over %0d moduli",
			n_in, n_out, phase_mod.size());
		$display("divisions without an inverse: %0d, mismatches: %0d", n_div_noinv, errors);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
